// ----- sv/pms_pkg.sv -----
package pms_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned CfgW    = 31;
    localparam int unsigned DtW     = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned WideW   = 64;
    localparam int unsigned QuotW   = 48;
    localparam int unsigned SumW    = 50;

    localparam logic [CfgW-1:0] MassReset     = 31'd65536;
    localparam logic [CfgW-1:0] MaxSpeedReset = 31'd13107200;
    localparam logic [CfgW-1:0] FrictionReset = 31'd26214400;

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] RegMass     = 2'd0;
    localparam logic [CfgIdxW-1:0] RegMaxSpeed = 2'd1;
    localparam logic [CfgIdxW-1:0] RegFriction = 2'd2;

    // datapath commands
    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_MUL_FX, CMD_MUL_FY, CMD_DIV_MASS, CMD_ADD_VX,
        CMD_ADD_VY, CMD_SQ_VX, CMD_SQ_VY, CMD_SQ_ADD, CMD_MUL_CAP2, CMD_SQRT,
        CMD_MUL_VX_CAP, CMD_MUL_VY_CAP, CMD_DIV_LEN, CMD_SET_VX, CMD_SET_VY,
        CMD_MUL_FRIC, CMD_LOAD_D, CMD_MUL_DD, CMD_ZERO_V, CMD_MUL_VX_D,
        CMD_MUL_VY_D, CMD_SUB_VX, CMD_SUB_VY, CMD_MUL_PX, CMD_MUL_PY,
        CMD_ADD_PX, CMD_ADD_PY, CMD_OUT
    } cmd_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_DVX_MUL, S_DVX_DIV, S_DVX_WAIT, S_DVX_ADD,
        S_DVY_MUL, S_DVY_DIV, S_DVY_WAIT, S_DVY_ADD,
        S_SQX, S_SQY, S_SQ_ADD, S_CAP_MUL, S_CAP_CHK, S_CAP_SQRT, S_CAP_SQW,
        S_CAPX_MUL, S_CAPX_DIV, S_CAPX_WAIT, S_CAPX_SET,
        S_CAPY_MUL, S_CAPY_DIV, S_CAPY_WAIT, S_CAPY_SET,
        S_FR_CHK, S_FR_MUL, S_FR_D, S_FR_SQX, S_FR_SQY, S_FR_SQ_ADD,
        S_FR_DD, S_FR_CHK2, S_FR_ZERO, S_FR_SQRT, S_FR_SQW,
        S_FRX_MUL, S_FRX_DIV, S_FRX_WAIT, S_FRX_SUB,
        S_FRY_MUL, S_FRY_DIV, S_FRY_WAIT, S_FRY_SUB,
        S_PX_MUL, S_PX_ADD, S_PY_MUL, S_PY_ADD, S_OUT
    } state_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic s2_gt;       // s2 above the last product
        logic force_zero;
        logic vel_zero;
        logic out_free;
    } status_t;

    // clamp to the signed 32-bit range
    function automatic logic signed [DataW-1:0] sat32(input logic signed [SumW-1:0] v);
        logic signed [SumW-1:0] hi;
        logic signed [SumW-1:0] lo;
        hi = SumW'(32'sh7FFF_FFFF);
        lo = -SumW'(33'sh0_8000_0000);
        if (v > hi)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < lo)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[DataW-1:0];
    endfunction

    // magnitude with a sign bit to signed
    function automatic logic signed [SumW-1:0] with_sign(input logic neg,
                                                         input logic [QuotW-1:0] mag);
        logic signed [SumW-1:0] m;
        m = $signed({2'b00, mag});
        with_sign = neg ? -m : m;
    endfunction

endpackage

// ----- sv/point_mass_motion_step.sv -----
// Channel  | Handshake              | Beat contents
// ---------+------------------------+---------------------------------------------
// in       | in_valid / in_ready    | force_x, force_y, time_step
// out      | out_valid / out_ready  | pos_x, pos_y, vel_x, vel_y, speed_capped,
//          |                        | came_to_rest
// cfg      | cfg_we (no wait)       | cfg_index, cfg_data
//
// One item at a time. Run time is set by the shared radix-2 divider and the square
// root unit: every step makes two divisions, the speed cap adds a root and two
// more, friction that slows the body adds the same, and friction that stops it
// outright adds no root or division.
// Reset clears position, velocity and the controller; registers take defaults.
// Results sit in an output register; the next beat is taken while one waits,
// and a result still unclaimed holds the controller in its output state.
module point_mass_motion_step (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [pms_pkg::DataW-1:0]   force_x,
    input  logic signed [pms_pkg::DataW-1:0]   force_y,
    input  logic [pms_pkg::DtW-1:0]            time_step,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pms_pkg::DataW-1:0]   pos_x,
    output logic signed [pms_pkg::DataW-1:0]   pos_y,
    output logic signed [pms_pkg::DataW-1:0]   vel_x,
    output logic signed [pms_pkg::DataW-1:0]   vel_y,
    output logic                               speed_capped,
    output logic                               came_to_rest,
    input  logic                               cfg_we,
    input  logic [pms_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [pms_pkg::CfgW-1:0]           cfg_data
);

    pms_pkg::cmd_t    cmd;
    pms_pkg::status_t status;

    pms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pms_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .force_x      (force_x),
        .force_y      (force_y),
        .time_step    (time_step),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .speed_capped (speed_capped),
        .came_to_rest (came_to_rest)
    );

endmodule

// ----- sv/pms_div.sv -----
module pms_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pms_pkg::WideW-1:0]   num,
    input  logic [pms_pkg::DataW-1:0]   den,
    output logic                        busy,
    output logic [pms_pkg::WideW-1:0]   quot
);

    localparam int unsigned CntW = $clog2(pms_pkg::WideW + 1);

    logic [CntW-1:0]             cnt_reg, cnt_next;
    logic [pms_pkg::WideW-1:0]   dq_reg, dq_next;
    logic [pms_pkg::DataW-1:0]   rem_reg, rem_next;
    logic [pms_pkg::DataW-1:0]   den_reg, den_next;
    logic [pms_pkg::DataW:0]     trial;
    logic                        qbit;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial    = {rem_reg, dq_reg[pms_pkg::WideW-1]};
        qbit     = (trial >= {1'b0, den_reg});
        cnt_next = cnt_reg;
        dq_next  = dq_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start)
        begin
            cnt_next = CntW'(pms_pkg::WideW);
            dq_next  = num;
            rem_next = '0;
            den_next = den;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dq_next  = {dq_reg[pms_pkg::WideW-2:0], qbit};
            rem_next = qbit ? pms_pkg::DataW'(trial - {1'b0, den_reg})
                            : trial[pms_pkg::DataW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = dq_reg;

endmodule

// ----- sv/pms_sqrt.sv -----
module pms_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pms_pkg::WideW-1:0]   rad,
    output logic                        busy,
    output logic [pms_pkg::DataW-1:0]   root
);

    localparam int unsigned Steps = pms_pkg::WideW / 2;
    localparam int unsigned CntW  = $clog2(Steps + 1);
    localparam int unsigned RemW  = pms_pkg::DataW + 2;
    localparam int unsigned TryW  = pms_pkg::DataW + 4;

    logic [CntW-1:0]             cnt_reg, cnt_next;
    logic [pms_pkg::WideW-1:0]   x_reg, x_next;
    logic [pms_pkg::DataW-1:0]   root_reg, root_next;
    logic [RemW-1:0]             rem_reg, rem_next;
    logic [TryW-1:0]             tmp;
    logic [TryW-1:0]             trial;
    logic                        take;

    // two radicand bits per cycle, one root bit
    always_comb
    begin
        tmp       = {rem_reg, x_reg[pms_pkg::WideW-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        take      = (tmp >= trial);
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next  = CntW'(Steps);
            x_next    = rad;
            root_next = '0;
            rem_next  = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            x_next    = {x_reg[pms_pkg::WideW-3:0], 2'b00};
            root_next = {root_reg[pms_pkg::DataW-2:0], take};
            rem_next  = take ? RemW'(tmp - trial) : RemW'(tmp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign busy = (cnt_reg != '0);
    assign root = root_reg;

endmodule

// ----- sv/pms_dp.sv -----
module pms_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pms_pkg::cmd_t                      cmd,
    output pms_pkg::status_t                   status,
    input  logic                               cfg_we,
    input  logic [pms_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [pms_pkg::CfgW-1:0]           cfg_data,
    input  logic signed [pms_pkg::DataW-1:0]   force_x,
    input  logic signed [pms_pkg::DataW-1:0]   force_y,
    input  logic [pms_pkg::DtW-1:0]            time_step,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pms_pkg::DataW-1:0]   pos_x,
    output logic signed [pms_pkg::DataW-1:0]   pos_y,
    output logic signed [pms_pkg::DataW-1:0]   vel_x,
    output logic signed [pms_pkg::DataW-1:0]   vel_y,
    output logic                               speed_capped,
    output logic                               came_to_rest
);

    localparam int unsigned W  = pms_pkg::DataW;
    localparam int unsigned WW = pms_pkg::WideW;
    localparam int unsigned QW = pms_pkg::QuotW;
    localparam int unsigned SW = pms_pkg::SumW;
    localparam int unsigned FB = pms_pkg::DtW;

    logic [pms_pkg::CfgW-1:0] mass_reg, max_reg, fric_dec_reg;

    logic signed [W-1:0] fx_reg, fy_reg, vx_reg, vy_reg, px_reg, py_reg;
    logic signed [W-1:0] vx_next, vy_next, px_next, py_next;
    logic [FB-1:0]       dt_reg;
    logic [WW-1:0]       mulp_reg, s2_reg, s2_next;
    logic [W-1:0]        d_reg;
    logic                capped_reg, capped_next, fric_reg, fric_next, out_valid_reg;

    logic signed [W-1:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic                cap_out_reg, rest_out_reg;

    logic [W-1:0]  abs_fx, abs_fy, abs_vx, abs_vy, mul_a, mul_b, div_den;
    logic          mul_en, div_start, sqrt_start, div_busy, sqrt_busy;
    logic [WW-1:0] div_q;
    logic [W-1:0]  sqrt_root;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg     <= pms_pkg::MassReset;
            max_reg      <= pms_pkg::MaxSpeedReset;
            fric_dec_reg <= pms_pkg::FrictionReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pms_pkg::RegMass:     mass_reg     <= cfg_data;
                pms_pkg::RegMaxSpeed: max_reg      <= cfg_data;
                pms_pkg::RegFriction: fric_dec_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // magnitudes
    assign abs_fx = fx_reg[W-1] ? W'(-fx_reg) : W'(fx_reg);
    assign abs_fy = fy_reg[W-1] ? W'(-fy_reg) : W'(fy_reg);
    assign abs_vx = vx_reg[W-1] ? W'(-vx_reg) : W'(vx_reg);
    assign abs_vy = vy_reg[W-1] ? W'(-vy_reg) : W'(vy_reg);

    // shared multiplier operand select and unit starts
    always_comb
    begin
        mul_en     = 1'b1;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        div_den    = sqrt_root;
        case (cmd)
            pms_pkg::CMD_MUL_FX:     begin mul_a = abs_fx; mul_b = W'(dt_reg); end
            pms_pkg::CMD_MUL_FY:     begin mul_a = abs_fy; mul_b = W'(dt_reg); end
            pms_pkg::CMD_SQ_VX:      begin mul_a = abs_vx; mul_b = abs_vx; end
            pms_pkg::CMD_SQ_VY:      begin mul_a = abs_vy; mul_b = abs_vy; end
            pms_pkg::CMD_MUL_CAP2:   begin mul_a = W'(max_reg); mul_b = W'(max_reg); end
            pms_pkg::CMD_MUL_VX_CAP: begin mul_a = abs_vx; mul_b = W'(max_reg); end
            pms_pkg::CMD_MUL_VY_CAP: begin mul_a = abs_vy; mul_b = W'(max_reg); end
            pms_pkg::CMD_MUL_FRIC:   begin mul_a = W'(fric_dec_reg); mul_b = W'(dt_reg); end
            pms_pkg::CMD_MUL_DD:     begin mul_a = d_reg; mul_b = d_reg; end
            pms_pkg::CMD_MUL_VX_D:   begin mul_a = abs_vx; mul_b = d_reg; end
            pms_pkg::CMD_MUL_VY_D:   begin mul_a = abs_vy; mul_b = d_reg; end
            pms_pkg::CMD_MUL_PX:     begin mul_a = abs_vx; mul_b = W'(dt_reg); end
            pms_pkg::CMD_MUL_PY:     begin mul_a = abs_vy; mul_b = W'(dt_reg); end
            pms_pkg::CMD_DIV_MASS:
            begin
                mul_en    = 1'b0;
                div_start = 1'b1;
                // a zero mass counts as one LSB
                div_den   = (mass_reg == '0) ? W'(1) : W'(mass_reg);
            end
            pms_pkg::CMD_DIV_LEN:    begin mul_en = 1'b0; div_start = 1'b1; end
            pms_pkg::CMD_SQRT:       begin mul_en = 1'b0; sqrt_start = 1'b1; end
            default:                 mul_en = 1'b0;
        endcase
    end

    pms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mulp_reg),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_q)
    );

    pms_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (s2_reg),
        .busy  (sqrt_busy),
        .root  (sqrt_root)
    );

    // state and working register updates
    always_comb
    begin
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        s2_next     = s2_reg;
        capped_next = capped_reg;
        fric_next   = fric_reg;
        case (cmd)
            pms_pkg::CMD_LOAD:
            begin
                capped_next = 1'b0;
                fric_next   = 1'b0;
            end
            pms_pkg::CMD_ADD_VX:
                vx_next = pms_pkg::sat32(SW'(vx_reg)
                                         + pms_pkg::with_sign(fx_reg[W-1], div_q[QW-1:0]));
            pms_pkg::CMD_ADD_VY:
                vy_next = pms_pkg::sat32(SW'(vy_reg)
                                         + pms_pkg::with_sign(fy_reg[W-1], div_q[QW-1:0]));
            pms_pkg::CMD_SQ_VY:  s2_next = mulp_reg;
            pms_pkg::CMD_SQ_ADD: s2_next = s2_reg + mulp_reg;
            pms_pkg::CMD_SET_VX:
            begin
                vx_next     = W'(pms_pkg::with_sign(vx_reg[W-1], div_q[QW-1:0]));
                capped_next = 1'b1;
            end
            pms_pkg::CMD_SET_VY:
                vy_next = W'(pms_pkg::with_sign(vy_reg[W-1], div_q[QW-1:0]));
            pms_pkg::CMD_MUL_FRIC: fric_next = 1'b1;
            pms_pkg::CMD_ZERO_V:
            begin
                vx_next = '0;
                vy_next = '0;
            end
            pms_pkg::CMD_SUB_VX:
                vx_next = W'(SW'(vx_reg) - pms_pkg::with_sign(vx_reg[W-1], div_q[QW-1:0]));
            pms_pkg::CMD_SUB_VY:
                vy_next = W'(SW'(vy_reg) - pms_pkg::with_sign(vy_reg[W-1], div_q[QW-1:0]));
            pms_pkg::CMD_ADD_PX:
                px_next = pms_pkg::sat32(SW'(px_reg)
                                         + pms_pkg::with_sign(vx_reg[W-1], mulp_reg[WW-1:FB]));
            pms_pkg::CMD_ADD_PY:
                py_next = pms_pkg::sat32(SW'(py_reg)
                                         + pms_pkg::with_sign(vy_reg[W-1], mulp_reg[WW-1:FB]));
            default: ;
        endcase
    end

    // body state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg        <= '0;
            vy_reg        <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            capped_reg    <= 1'b0;
            fric_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vx_reg     <= vx_next;
            vy_reg     <= vy_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            capped_reg <= capped_next;
            fric_reg   <= fric_next;
            if (cmd == pms_pkg::CMD_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
        if (mul_en)
            mulp_reg <= WW'(mul_a) * WW'(mul_b);
        if (cmd == pms_pkg::CMD_LOAD)
        begin
            fx_reg <= force_x;
            fy_reg <= force_y;
            dt_reg <= time_step;
        end
        if (cmd == pms_pkg::CMD_LOAD_D)
            d_reg <= mulp_reg[W+FB-1:FB];
        if (cmd == pms_pkg::CMD_OUT)
        begin
            pos_x_reg    <= px_reg;
            pos_y_reg    <= py_reg;
            vel_x_reg    <= vx_reg;
            vel_y_reg    <= vy_reg;
            cap_out_reg  <= capped_reg;
            rest_out_reg <= fric_reg && (vx_reg == '0) && (vy_reg == '0);
        end
    end

    assign status.div_busy   = div_busy;
    assign status.sqrt_busy  = sqrt_busy;
    assign status.s2_gt      = (s2_reg > mulp_reg);
    assign status.force_zero = (fx_reg == '0) && (fy_reg == '0);
    assign status.vel_zero   = (vx_reg == '0) && (vy_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign vel_x        = vel_x_reg;
    assign vel_y        = vel_y_reg;
    assign speed_capped = cap_out_reg;
    assign came_to_rest = rest_out_reg;

endmodule

// ----- sv/pms_ctrl.sv -----
module pms_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pms_pkg::status_t  status,
    output pms_pkg::cmd_t     cmd
);

    pms_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pms_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pms_pkg::S_IDLE:      if (in_valid) state_next = pms_pkg::S_DVX_MUL;
            pms_pkg::S_DVX_MUL:   state_next = pms_pkg::S_DVX_DIV;
            pms_pkg::S_DVX_DIV:   state_next = pms_pkg::S_DVX_WAIT;
            pms_pkg::S_DVX_WAIT:  if (!status.div_busy) state_next = pms_pkg::S_DVX_ADD;
            pms_pkg::S_DVX_ADD:   state_next = pms_pkg::S_DVY_MUL;
            pms_pkg::S_DVY_MUL:   state_next = pms_pkg::S_DVY_DIV;
            pms_pkg::S_DVY_DIV:   state_next = pms_pkg::S_DVY_WAIT;
            pms_pkg::S_DVY_WAIT:  if (!status.div_busy) state_next = pms_pkg::S_DVY_ADD;
            pms_pkg::S_DVY_ADD:   state_next = pms_pkg::S_SQX;
            pms_pkg::S_SQX:       state_next = pms_pkg::S_SQY;
            pms_pkg::S_SQY:       state_next = pms_pkg::S_SQ_ADD;
            pms_pkg::S_SQ_ADD:    state_next = pms_pkg::S_CAP_MUL;
            pms_pkg::S_CAP_MUL:   state_next = pms_pkg::S_CAP_CHK;
            pms_pkg::S_CAP_CHK:
                state_next = status.s2_gt ? pms_pkg::S_CAP_SQRT : pms_pkg::S_FR_CHK;
            pms_pkg::S_CAP_SQRT:  state_next = pms_pkg::S_CAP_SQW;
            pms_pkg::S_CAP_SQW:   if (!status.sqrt_busy) state_next = pms_pkg::S_CAPX_MUL;
            pms_pkg::S_CAPX_MUL:  state_next = pms_pkg::S_CAPX_DIV;
            pms_pkg::S_CAPX_DIV:  state_next = pms_pkg::S_CAPX_WAIT;
            pms_pkg::S_CAPX_WAIT: if (!status.div_busy) state_next = pms_pkg::S_CAPX_SET;
            pms_pkg::S_CAPX_SET:  state_next = pms_pkg::S_CAPY_MUL;
            pms_pkg::S_CAPY_MUL:  state_next = pms_pkg::S_CAPY_DIV;
            pms_pkg::S_CAPY_DIV:  state_next = pms_pkg::S_CAPY_WAIT;
            pms_pkg::S_CAPY_WAIT: if (!status.div_busy) state_next = pms_pkg::S_CAPY_SET;
            pms_pkg::S_CAPY_SET:  state_next = pms_pkg::S_FR_CHK;
            pms_pkg::S_FR_CHK:
                state_next = (status.force_zero && !status.vel_zero) ? pms_pkg::S_FR_MUL
                                                                     : pms_pkg::S_PX_MUL;
            pms_pkg::S_FR_MUL:    state_next = pms_pkg::S_FR_D;
            pms_pkg::S_FR_D:      state_next = pms_pkg::S_FR_SQX;
            pms_pkg::S_FR_SQX:    state_next = pms_pkg::S_FR_SQY;
            pms_pkg::S_FR_SQY:    state_next = pms_pkg::S_FR_SQ_ADD;
            pms_pkg::S_FR_SQ_ADD: state_next = pms_pkg::S_FR_DD;
            pms_pkg::S_FR_DD:     state_next = pms_pkg::S_FR_CHK2;
            pms_pkg::S_FR_CHK2:
                state_next = status.s2_gt ? pms_pkg::S_FR_SQRT : pms_pkg::S_FR_ZERO;
            pms_pkg::S_FR_ZERO:   state_next = pms_pkg::S_PX_MUL;
            pms_pkg::S_FR_SQRT:   state_next = pms_pkg::S_FR_SQW;
            pms_pkg::S_FR_SQW:    if (!status.sqrt_busy) state_next = pms_pkg::S_FRX_MUL;
            pms_pkg::S_FRX_MUL:   state_next = pms_pkg::S_FRX_DIV;
            pms_pkg::S_FRX_DIV:   state_next = pms_pkg::S_FRX_WAIT;
            pms_pkg::S_FRX_WAIT:  if (!status.div_busy) state_next = pms_pkg::S_FRX_SUB;
            pms_pkg::S_FRX_SUB:   state_next = pms_pkg::S_FRY_MUL;
            pms_pkg::S_FRY_MUL:   state_next = pms_pkg::S_FRY_DIV;
            pms_pkg::S_FRY_DIV:   state_next = pms_pkg::S_FRY_WAIT;
            pms_pkg::S_FRY_WAIT:  if (!status.div_busy) state_next = pms_pkg::S_FRY_SUB;
            pms_pkg::S_FRY_SUB:   state_next = pms_pkg::S_PX_MUL;
            pms_pkg::S_PX_MUL:    state_next = pms_pkg::S_PX_ADD;
            pms_pkg::S_PX_ADD:    state_next = pms_pkg::S_PY_MUL;
            pms_pkg::S_PY_MUL:    state_next = pms_pkg::S_PY_ADD;
            pms_pkg::S_PY_ADD:    state_next = pms_pkg::S_OUT;
            pms_pkg::S_OUT:       if (status.out_free) state_next = pms_pkg::S_IDLE;
            default:              state_next = pms_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = pms_pkg::CMD_NONE;
        case (state_reg)
            pms_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd = pms_pkg::CMD_LOAD;
            end
            pms_pkg::S_DVX_MUL:   cmd = pms_pkg::CMD_MUL_FX;
            pms_pkg::S_DVX_DIV:   cmd = pms_pkg::CMD_DIV_MASS;
            pms_pkg::S_DVX_ADD:   cmd = pms_pkg::CMD_ADD_VX;
            pms_pkg::S_DVY_MUL:   cmd = pms_pkg::CMD_MUL_FY;
            pms_pkg::S_DVY_DIV:   cmd = pms_pkg::CMD_DIV_MASS;
            pms_pkg::S_DVY_ADD:   cmd = pms_pkg::CMD_ADD_VY;
            pms_pkg::S_SQX:       cmd = pms_pkg::CMD_SQ_VX;
            pms_pkg::S_SQY:       cmd = pms_pkg::CMD_SQ_VY;
            pms_pkg::S_SQ_ADD:    cmd = pms_pkg::CMD_SQ_ADD;
            pms_pkg::S_CAP_MUL:   cmd = pms_pkg::CMD_MUL_CAP2;
            pms_pkg::S_CAP_SQRT:  cmd = pms_pkg::CMD_SQRT;
            pms_pkg::S_CAPX_MUL:  cmd = pms_pkg::CMD_MUL_VX_CAP;
            pms_pkg::S_CAPX_DIV:  cmd = pms_pkg::CMD_DIV_LEN;
            pms_pkg::S_CAPX_SET:  cmd = pms_pkg::CMD_SET_VX;
            pms_pkg::S_CAPY_MUL:  cmd = pms_pkg::CMD_MUL_VY_CAP;
            pms_pkg::S_CAPY_DIV:  cmd = pms_pkg::CMD_DIV_LEN;
            pms_pkg::S_CAPY_SET:  cmd = pms_pkg::CMD_SET_VY;
            pms_pkg::S_FR_MUL:    cmd = pms_pkg::CMD_MUL_FRIC;
            pms_pkg::S_FR_D:      cmd = pms_pkg::CMD_LOAD_D;
            pms_pkg::S_FR_SQX:    cmd = pms_pkg::CMD_SQ_VX;
            pms_pkg::S_FR_SQY:    cmd = pms_pkg::CMD_SQ_VY;
            pms_pkg::S_FR_SQ_ADD: cmd = pms_pkg::CMD_SQ_ADD;
            pms_pkg::S_FR_DD:     cmd = pms_pkg::CMD_MUL_DD;
            pms_pkg::S_FR_ZERO:   cmd = pms_pkg::CMD_ZERO_V;
            pms_pkg::S_FR_SQRT:   cmd = pms_pkg::CMD_SQRT;
            pms_pkg::S_FRX_MUL:   cmd = pms_pkg::CMD_MUL_VX_D;
            pms_pkg::S_FRX_DIV:   cmd = pms_pkg::CMD_DIV_LEN;
            pms_pkg::S_FRX_SUB:   cmd = pms_pkg::CMD_SUB_VX;
            pms_pkg::S_FRY_MUL:   cmd = pms_pkg::CMD_MUL_VY_D;
            pms_pkg::S_FRY_DIV:   cmd = pms_pkg::CMD_DIV_LEN;
            pms_pkg::S_FRY_SUB:   cmd = pms_pkg::CMD_SUB_VY;
            pms_pkg::S_PX_MUL:    cmd = pms_pkg::CMD_MUL_PX;
            pms_pkg::S_PX_ADD:    cmd = pms_pkg::CMD_ADD_PX;
            pms_pkg::S_PY_MUL:    cmd = pms_pkg::CMD_MUL_PY;
            pms_pkg::S_PY_ADD:    cmd = pms_pkg::CMD_ADD_PY;
            pms_pkg::S_OUT:       if (status.out_free) cmd = pms_pkg::CMD_OUT;
            default:              cmd = pms_pkg::CMD_NONE;
        endcase
    end

endmodule

// ----- tb/sv/tb_point_mass_motion_step.sv -----
module tb_point_mass_motion_step;

    localparam int unsigned DataW   = pms_pkg::DataW;
    localparam int unsigned CfgW    = pms_pkg::CfgW;
    localparam int unsigned DtW     = pms_pkg::DtW;
    localparam int unsigned CfgIdxW = pms_pkg::CfgIdxW;

    localparam logic [CfgW-1:0] MassReset     = pms_pkg::MassReset;
    localparam logic [CfgW-1:0] MaxSpeedReset = pms_pkg::MaxSpeedReset;
    localparam logic [CfgW-1:0] FrictionReset = pms_pkg::FrictionReset;

    localparam logic [CfgIdxW-1:0] RegMass     = pms_pkg::RegMass;
    localparam logic [CfgIdxW-1:0] RegMaxSpeed = pms_pkg::RegMaxSpeed;
    localparam logic [CfgIdxW-1:0] RegFriction = pms_pkg::RegFriction;

    // index beyond the register file, must be ignored
    localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

    typedef struct {
        logic signed [DataW-1:0] pos_x;
        logic signed [DataW-1:0] pos_y;
        logic signed [DataW-1:0] vel_x;
        logic signed [DataW-1:0] vel_y;
        logic                    capped;
        logic                    rest;
    } motion_t;

    // directed table: either a beat or a register write
    typedef struct {
        logic                    is_cfg;
        logic [CfgIdxW-1:0]      idx;
        logic [CfgW-1:0]         data;
        logic signed [DataW-1:0] fx;
        logic signed [DataW-1:0] fy;
        logic [DtW-1:0]          dt;
        logic                    typed;
        motion_t                 want;
    } step_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [DataW-1:0] force_x;
    logic signed [DataW-1:0] force_y;
    logic [DtW-1:0] time_step;
    logic out_valid;
    logic out_ready;
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_y;
    logic signed [DataW-1:0] vel_x;
    logic signed [DataW-1:0] vel_y;
    logic speed_capped;
    logic came_to_rest;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgW-1:0] cfg_data;

    // predictor copy of the block
    logic [CfgW-1:0] mdl_mass;
    logic [CfgW-1:0] mdl_cap;
    logic [CfgW-1:0] mdl_fric;
    longint mdl_px;
    longint mdl_py;
    longint mdl_vx;
    longint mdl_vy;

    motion_t motion_q[$];
    int      mismatches;
    bit      no_idle;

    point_mass_motion_step i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .force_x      (force_x),
        .force_y      (force_y),
        .time_step    (time_step),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .speed_capped (speed_capped),
        .came_to_rest (came_to_rest),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // bitwise integer square root, floor
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // one Euler step: updates the predicted state, returns the beat
    function automatic motion_t euler_step(input logic signed [DataW-1:0] fx,
                                           input logic signed [DataW-1:0] fy,
                                           input logic [DtW-1:0] dt);
        longint          f_x;
        longint          f_y;
        longint          t;
        longint          m;
        longint          vx;
        longint          vy;
        longint          len;
        longint          cap;
        longint unsigned s2;
        longint unsigned d;
        motion_t         r;
        f_x = fx;
        f_y = fy;
        t = longint'(dt);
        m = (mdl_mass == 0) ? 64'sd1 : longint'(mdl_mass);
        cap = longint'(mdl_cap);
        r.capped = 1'b0;
        r.rest = 1'b0;
        vx = clamp32(mdl_vx + (f_x * t) / m);
        vy = clamp32(mdl_vy + (f_y * t) / m);
        // speed cap
        s2 = vx * vx + vy * vy;
        if (s2 > longint'(mdl_cap) * longint'(mdl_cap))
        begin
            len = longint'(floor_root(s2));
            vx = (vx * cap) / len;
            vy = (vy * cap) / len;
            r.capped = 1'b1;
        end
        // friction when coasting
        if (f_x == 0 && f_y == 0 && (vx != 0 || vy != 0))
        begin
            d = (longint'(mdl_fric) * t) >> 16;
            s2 = vx * vx + vy * vy;
            if (d * d >= s2)
            begin
                vx = 0;
                vy = 0;
            end
            else
            begin
                len = longint'(floor_root(s2));
                vx = vx - (vx * longint'(d)) / len;
                vy = vy - (vy * longint'(d)) / len;
            end
            r.rest = (vx == 0 && vy == 0);
        end
        mdl_vx = vx;
        mdl_vy = vy;
        mdl_px = clamp32(mdl_px + (vx * t) / 65536);
        mdl_py = clamp32(mdl_py + (vy * t) / 65536);
        r.pos_x = mdl_px[31:0];
        r.pos_y = mdl_py[31:0];
        r.vel_x = vx[31:0];
        r.vel_y = vy[31:0];
        return r;
    endfunction

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    // one input beat; valid stays high into the next beat when no gap is drawn
    task automatic push_force(input logic signed [DataW-1:0] fx,
                              input logic signed [DataW-1:0] fy,
                              input logic [DtW-1:0] dt,
                              input logic typed,
                              input motion_t want);
        int      gap;
        motion_t got;
        gap = idle_draw();
        repeat (gap)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        force_x = fx;
        force_y = fy;
        time_step = dt;
        do
            @(posedge clk);
        while (!in_ready);
        got = euler_step(fx, fy, dt);
        motion_q.push_back(typed ? want : got);
        @(negedge clk);
    endtask

    // registers only change with the block idle
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
        in_valid = 1'b0;
        while (motion_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        case (idx)
            RegMass:     mdl_mass = data;
            RegMaxSpeed: mdl_cap = data;
            RegFriction: mdl_fric = data;
            default:     ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [CfgW-1:0] cfg_draw();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return CfgW'($urandom_range(1, 65536));
            3:       return CfgW'($urandom_range(65536, 65536 * 600));
            default: return CfgW'($urandom);
        endcase
    endfunction

    function automatic logic signed [DataW-1:0] force_draw();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return DataW'($urandom_range(0, 2 * 65536 * 300)) - DataW'(65536 * 300);
            2:       return 32'sh7FFF_FFFF;
            3:       return 32'sh8000_0000;
            default: return DataW'($urandom);
        endcase
    endfunction

    // result side: random stalls, field-by-field compare
    initial
    begin
        int      stall;
        motion_t exp_beat;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = idle_draw();
            repeat (stall)
            begin
                out_ready = 1'b0;
                @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (motion_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                exp_beat = motion_q.pop_front();
                if (pos_x !== exp_beat.pos_x)
                begin
                    $error("pos_x: expected %0d, got %0d", exp_beat.pos_x, pos_x);
                    mismatches++;
                end
                if (pos_y !== exp_beat.pos_y)
                begin
                    $error("pos_y: expected %0d, got %0d", exp_beat.pos_y, pos_y);
                    mismatches++;
                end
                if (vel_x !== exp_beat.vel_x)
                begin
                    $error("vel_x: expected %0d, got %0d", exp_beat.vel_x, vel_x);
                    mismatches++;
                end
                if (vel_y !== exp_beat.vel_y)
                begin
                    $error("vel_y: expected %0d, got %0d", exp_beat.vel_y, vel_y);
                    mismatches++;
                end
                if (speed_capped !== exp_beat.capped)
                begin
                    $error("speed_capped: expected %0b, got %0b", exp_beat.capped,
                           speed_capped);
                    mismatches++;
                end
                if (came_to_rest !== exp_beat.rest)
                begin
                    $error("came_to_rest: expected %0b, got %0b", exp_beat.rest,
                           came_to_rest);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // stimulus
    initial
    begin
        step_row_t rows[$];
        step_row_t row;
        motion_t   still;
        logic signed [DataW-1:0] fx;
        logic signed [DataW-1:0] fy;
        logic [DtW-1:0] dt;
        in_valid = 1'b0;
        force_x = '0;
        force_y = '0;
        time_step = '0;
        cfg_we = 1'b0;
        cfg_index = RegMass;
        cfg_data = '0;
        mismatches = 0;
        no_idle = 1'b0;
        mdl_mass = MassReset;
        mdl_cap = MaxSpeedReset;
        mdl_fric = FrictionReset;
        mdl_px = 0;
        mdl_py = 0;
        mdl_vx = 0;
        mdl_vy = 0;
        still = '{default: '0};
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // at rest with zero time step nothing moves, whatever the force
        rows.push_back('{0, RegMass, '0, 0, 0, 0, 1, still});
        rows.push_back('{0, RegMass, '0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1, still});
        // default registers: push, cap, then coast to a stop
        rows.push_back('{0, RegMass, '0, 32'sd65536, 0, 16'hFFFF, 0, still});
        rows.push_back('{0, RegMass, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF, 0, still});
        rows.push_back('{0, RegMass, '0, 0, 0, 16'h1000, 0, still});
        rows.push_back('{0, RegMass, '0, 0, 0, 16'hFFFF, 0, still});
        // zero mass counts as one LSB; huge cap, no friction: velocity saturates
        rows.push_back('{1, RegMass, '0, 0, 0, 0, 0, still});
        rows.push_back('{1, RegMaxSpeed, '1, 0, 0, 0, 0, still});
        rows.push_back('{1, RegFriction, '0, 0, 0, 0, 0, still});
        rows.push_back('{0, RegMass, '0, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 0, still});
        rows.push_back('{0, RegMass, '0, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 0, still});
        rows.push_back('{0, RegMass, '0, 0, 0, 16'hFFFF, 0, still});
        rows.push_back('{0, RegMass, '0, 0, 0, 16'hFFFF, 0, still});
        rows.push_back('{0, RegMass, '0, 0, 0, 16'hFFFF, 0, still});
        // zero cap stops any motion
        rows.push_back('{1, RegMaxSpeed, '0, 0, 0, 0, 0, still});
        rows.push_back('{0, RegMass, '0, -32'sd65536, 32'sd3, 16'h8000, 0, still});
        // unknown index leaves the registers alone
        rows.push_back('{1, RegUnused, '1, 0, 0, 0, 0, still});
        rows.push_back('{1, RegMass, '1, 0, 0, 0, 0, still});
        rows.push_back('{1, RegMaxSpeed, 31'd65536 * 10, 0, 0, 0, 0, still});
        rows.push_back('{1, RegFriction, '1, 0, 0, 0, 0, still});
        rows.push_back('{0, RegMass, '0, 32'sh7FFF_FFFF, -32'sd1, 16'hFFFF, 0, still});
        rows.push_back('{0, RegMass, '0, 0, 0, 16'h0001, 0, still});
        rows.push_back('{0, RegMass, '0, 0, 0, 16'hFFFF, 0, still});

        foreach (rows[i])
        begin
            row = rows[i];
            if (row.is_cfg)
                write_reg(row.idx, row.data);
            else
                push_force(row.fx, row.fy, row.dt, row.typed, row.want);
        end

        // random phases, each with fresh registers
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(RegMass, cfg_draw());
            write_reg(RegMaxSpeed, cfg_draw());
            write_reg(RegFriction, cfg_draw());
            if ($urandom_range(0, 3) == 0)
                write_reg(RegUnused, CfgW'($urandom));
            no_idle = (ph % 4 == 3);
            for (int n = 0; n < 50; n++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    fx = '0;
                    fy = '0;
                end
                else
                begin
                    fx = force_draw();
                    fy = force_draw();
                end
                dt = ($urandom_range(0, 7) == 0) ? DtW'(0) : DtW'($urandom);
                push_force(fx, fy, dt, 1'b0, still);
            end
        end
        no_idle = 1'b0;

        in_valid = 1'b0;
        while (motion_q.size() != 0)
            @(negedge clk);
        repeat (500) @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
